@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the AGC RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted.
`define AGC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property, also checked during reset.
`define AGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define AGC_ASSERT(lbl, clk, rst_n, prop, msg)
`define AGC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/agc_pkg.sv @@
// Types and constants shared by the automatic gain control modules.
`timescale 1ns / 1ps

package agc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 24;
	localparam int GAIN_FRAC  = 16;
	localparam int COEFF_W    = 16;
	localparam int MINGAIN_W  = 17;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int LEVEL_W    = 17;
	localparam int ERR_W      = 18;
	localparam int PROD_W     = 40;
	localparam int MUL_A_W    = 18;
	localparam int MUL_B_W    = 25;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int STEP_W     = 34;

	localparam logic [GAIN_W-1:0]    GAIN_ONE        = 24'd65536;
	localparam logic [15:0]          TARGET_RST      = 16'd32768;
	localparam logic [COEFF_W-1:0]   ATTACK_RST      = 16'd655;
	localparam logic [COEFF_W-1:0]   RELEASE_RST     = 16'd66;
	localparam logic [GAIN_W-1:0]    MAX_GAIN_RST    = 24'd6553600;
	localparam logic [MINGAIN_W-1:0] MIN_GAIN_RST    = 17'd655;
	localparam logic [LEVEL_W-1:0]   LEVEL_FULL      = 17'd65536;
	localparam logic [SAMPLE_W-1:0]  SAMPLE_POS_FULL = 16'h7fff;
	localparam logic [SAMPLE_W-1:0]  SAMPLE_NEG_FULL = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET  = 3'd0,
		REG_ATTACK  = 3'd1,
		REG_RELEASE = 3'd2,
		REG_MAX     = 3'd3,
		REG_MIN     = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_LEVEL,
		ST_MUL_E,
		ST_UPDATE
	} state_t;

	typedef enum logic {
		MUL_PROD,
		MUL_ERR
	} mul_sel_t;

	typedef struct packed {
		logic [15:0]          target_level;
		logic [COEFF_W-1:0]   attack_coeff;
		logic [COEFF_W-1:0]   release_coeff;
		logic [GAIN_W-1:0]    max_gain;
		logic [MINGAIN_W-1:0] min_gain;
	} cfg_t;

	typedef struct packed {
		logic     load_sample;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     load_level;
		logic     load_gain;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

@@ hw/rtl/automatic_gain_control.sv @@
// Top level of the automatic gain control block.
`timescale 1ns / 1ps

// Automatic gain control: each transfer of a Q1.15 sample yields one result, the sample
// times the current Q8.16 gain, rounded half up and saturated, with a clip flag. The gain
// then moves toward the target level by the attack or release coefficient and is clamped
// to [min_gain, max_gain]; reset sets it to 1.0. One shared 18x25 multiplier forms first
// the product and then the gain step; a new sample is taken only after the product,
// level, error and gain update states, later while a stalled receiver holds the output.
// The user must write registers only while no item is in flight; it is not enforced.
module automatic_gain_control
	import agc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic                       clipped
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	agc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	agc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	agc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.st         (st),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.clipped    (clipped)
	);

endmodule

@@ hw/rtl/agc_cfg.sv @@
// Configuration register file of the automatic gain control.
`timescale 1ns / 1ps

module agc_cfg
	import agc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_level  <= TARGET_RST;
			cfg_q.attack_coeff  <= ATTACK_RST;
			cfg_q.release_coeff <= RELEASE_RST;
			cfg_q.max_gain      <= MAX_GAIN_RST;
			cfg_q.min_gain      <= MIN_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET:  cfg_q.target_level  <= cfg_data[15:0];
				REG_ATTACK:  cfg_q.attack_coeff  <= cfg_data[COEFF_W-1:0];
				REG_RELEASE: cfg_q.release_coeff <= cfg_data[COEFF_W-1:0];
				REG_MAX:     cfg_q.max_gain      <= cfg_data[GAIN_W-1:0];
				REG_MIN:     cfg_q.min_gain      <= cfg_data[MINGAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/agc_ctrl.sv @@
// Sequencing state machine of the automatic gain control.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module agc_ctrl
	import agc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_MUL_P;
			end
			ST_MUL_P:  state_nxt = ST_LEVEL;
			ST_LEVEL: begin
				if (!st.out_busy) state_nxt = ST_MUL_E;
			end
			ST_MUL_E:  state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_PROD;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.load_sample = in_valid;
			end
			ST_MUL_P: begin
				cmd.mul_en = 1'b1;
			end
			ST_LEVEL: begin
				cmd.load_level = !st.out_busy;
			end
			ST_MUL_E: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR;
			end
			ST_UPDATE: begin
				cmd.load_gain = 1'b1;
			end
			default: ;
		endcase
	end

	`AGC_ASSERT(a_accept_starts, clk, arst_n, in_valid && !in_stall |=> state_q == ST_MUL_P, "transfer did not start the product multiply")
	`AGC_ASSERT(a_level_waits, clk, arst_n, state_q == ST_LEVEL && st.out_busy |=> state_q == ST_LEVEL, "left level state while output still held")
	`AGC_ASSERT(a_update_follows, clk, arst_n, state_q == ST_MUL_E |=> cmd.load_gain, "gain update did not follow error multiply")

endmodule

@@ hw/rtl/agc_dp.sv @@
// Datapath of the automatic gain control: shared multiplier, output and gain registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module agc_dp
	import agc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  cmd_t                       cmd,
	output stat_t                      st,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic                       clipped
);

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [GAIN_W-1:0]          gain_q;
	logic signed [ERR_W-1:0]    err_q;
	logic signed [MUL_P_W-1:0]  mul_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       clipped_q;
	logic                       out_valid_q;

	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic [COEFF_W-1:0]         coeff;

	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W:0]     rnd_sum;
	logic signed [24:0]         o_full;
	logic signed [SAMPLE_W-1:0] o_sat;
	logic                       o_clip;
	logic [PROD_W-1:0]          mag;
	logic [LEVEL_W-1:0]         level;
	logic signed [ERR_W-1:0]    err_c;

	logic signed [STEP_W:0]     step_sum;
	logic signed [18:0]         delta;
	logic signed [25:0]         g_sum;
	logic signed [25:0]         g_hi;
	logic [GAIN_W-1:0]          gain_nxt;

	// error > 0 selects the attack step
	assign coeff = (!err_q[ERR_W-1] && (err_q != '0)) ? cfg.attack_coeff : cfg.release_coeff;

	always_comb begin
		if (cmd.mul_sel == MUL_ERR) begin
			mul_a = err_q;
			mul_b = $signed({9'd0, coeff});
		end else begin
			mul_a = $signed({{(MUL_A_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q});
			mul_b = $signed({1'b0, gain_q});
		end
	end

	// product stage: round half up to Q1.15, saturate, level from truncated magnitude
	always_comb begin
		prod    = mul_q[PROD_W-1:0];
		rnd_sum = {prod[PROD_W-1], prod} + 41'sd32768;
		o_full  = rnd_sum[PROD_W:GAIN_FRAC];
		if (o_full > 25'sd32767) begin
			o_sat  = SAMPLE_POS_FULL;
			o_clip = 1'b1;
		end else if (o_full < -25'sd32768) begin
			o_sat  = SAMPLE_NEG_FULL;
			o_clip = 1'b1;
		end else begin
			o_sat  = o_full[SAMPLE_W-1:0];
			o_clip = 1'b0;
		end
		mag   = prod[PROD_W-1] ? PROD_W'(-prod) : prod;
		level = (mag[PROD_W-1:15] > 25'(LEVEL_FULL)) ? LEVEL_FULL : mag[31:15];
		err_c = $signed({2'b00, cfg.target_level}) - $signed({1'b0, level});
	end

	// gain stage: round the Q0.32 step to Q8.16, add, clamp high then low
	always_comb begin
		step_sum = {mul_q[STEP_W-1], mul_q[STEP_W-1:0]} + 35'sd32768;
		delta    = step_sum[STEP_W:GAIN_FRAC];
		g_sum    = $signed({2'b00, gain_q}) + {{7{delta[18]}}, delta};
		g_hi     = (g_sum > $signed({2'b00, cfg.max_gain})) ? $signed({2'b00, cfg.max_gain})
		                                                    : g_sum;
		gain_nxt = (g_hi < $signed({9'd0, cfg.min_gain})) ? {7'd0, cfg.min_gain}
		                                                 : g_hi[GAIN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) sample_q <= in_sample;
		if (cmd.mul_en) mul_q <= mul_a * mul_b;
		if (cmd.load_level) begin
			err_q        <= err_c;
			out_sample_q <= o_sat;
			clipped_q    <= o_clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_gain) gain_q <= gain_nxt;
			if (cmd.load_level) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.out_busy = out_valid_q && out_stall;
	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign clipped     = clipped_q;

	`AGC_ASSERT(a_gain_bounded, clk, arst_n, cmd.load_gain |=> (gain_q <= $past(cfg.max_gain)) || (gain_q == 24'($past(cfg.min_gain))), "gain left its bounds")
	`AGC_ASSERT(a_result_shown, clk, arst_n, cmd.load_level |=> out_valid_q, "result not presented")
	`AGC_ASSERT(a_clip_value, clk, arst_n, out_valid_q && clipped_q |-> (out_sample_q == SAMPLE_POS_FULL) || (out_sample_q == SAMPLE_NEG_FULL), "clipped result not at full scale")
	`AGC_ASSERT_ALWAYS(a_no_overwrite, clk, !(cmd.load_level && st.out_busy), "held result overwritten")

endmodule
